### rtl/rri_pkg.sv
`default_nettype none
package rri_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 48;

  // quotient bits kept by the divider; offsets clamp at 2^(QUOT_BITS-1)
  localparam int QUOT_BITS  = 34;
  // square root: operand width and one result bit per step
  localparam int SQ_BITS    = 36;
  localparam int SQRT_STEPS = 18;
  localparam int DC_BITS    = 18;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CORNER_A     = 3'd0,
    REG_CORNER_B     = 3'd1,
    REG_CORNER_C     = 3'd2,
    REG_CORNER_D     = 3'd3,
    REG_PLANE_NORMAL = 3'd4,
    REG_PLANE_OFFSET = 3'd5
  } reg_idx_t;

endpackage
`default_nettype wire

### rtl/ray_rectangle_intersect.sv
`default_nettype none
// Channel  Handshake            Beat
// in_      start / busy         cmd, origin_x/y/z, dir_x/y/z, max_length
// out_     out_valid strobe     hit, distance, point_x/y/z
// cfg_     cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One ray per cycle; busy stays low. Each beat taken passes through the dot
// product and multiply stages, 34 divider steps (one quotient bit a stage),
// the rounding, point and edge test stages, 18 square root steps (one result
// bit a stage) and the output register.
// rst_n clears the valid bits and the configuration registers. out_ cannot stall.
module ray_rectangle_intersect #(
  parameter int COORD_BITS = rri_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_cmd,
  input  logic signed [COORD_BITS-1:0]       in_origin_x,
  input  logic signed [COORD_BITS-1:0]       in_origin_y,
  input  logic signed [COORD_BITS-1:0]       in_origin_z,
  input  logic signed [COORD_BITS-1:0]       in_dir_x,
  input  logic signed [COORD_BITS-1:0]       in_dir_y,
  input  logic signed [COORD_BITS-1:0]       in_dir_z,
  input  logic [15:0]                        in_max_length,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rri_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rri_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [15:0]                        out_distance,
  output logic signed [COORD_BITS-1:0]       out_point_x,
  output logic signed [COORD_BITS-1:0]       out_point_y,
  output logic signed [COORD_BITS-1:0]       out_point_z
);
  import rri_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int PRW  = 16 + CB;
  localparam int NUMW = ((PRW > 32) ? PRW : 32) + 2;
  localparam int DENW = PRW + 2;
  localparam int NL   = NUMW / 2;
  localparam int NH   = NUMW - NL;
  localparam int PW   = CB + NUMW;
  localparam int RW   = DENW + 1;
  localparam int QB   = QUOT_BITS;
  localparam int TOPW = PW - QB;
  localparam int CW   = (TOPW > DENW) ? TOPW : DENW;
  localparam int SW   = ((CB > QB + 1) ? CB : QB + 1) + 1;
  localparam int VPW  = ((CB > 16) ? CB : 16) + 1;
  localparam int IPW  = 17 + VPW;
  localparam int DOTW = IPW + 2;
  localparam int SQW  = SQ_BITS;
  localparam int ST   = SQRT_STEPS;
  localparam int LAT  = 10 + QB + ST;

  localparam logic [QB:0]          LIM    = (QB + 1)'(1) << (QB - 1);
  localparam logic [DC_BITS-1:0]   DC_LIM = DC_BITS'(1) << (DC_BITS - 1);
  localparam logic signed [SW-1:0] CMAXV  = SW'((longint'(1) << (CB - 1)) - 1);
  localparam logic signed [SW-1:0] CMINV  = -CMAXV - SW'(1);

  typedef struct packed {
    logic                 cmd;
    logic                 miss;
    logic [15:0]          maxlen;
    logic [2:0][CB-1:0]   e;
    logic [2:0]           wneg;
  } side_t;

  typedef struct packed {
    logic                 miss;
    logic [2:0][CB-1:0]   p;
  } fin_t;

  // configuration
  logic [47:0]        corner_r [4];
  logic [47:0]        normal_r;
  logic signed [31:0] offset_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) corner_r[i] <= '0;
      normal_r <= '0;
      offset_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CORNER_A:     corner_r[0] <= cfg_data;
        REG_CORNER_B:     corner_r[1] <= cfg_data;
        REG_CORNER_C:     corner_r[2] <= cfg_data;
        REG_CORNER_D:     corner_r[3] <= cfg_data;
        REG_PLANE_NORMAL: normal_r    <= cfg_data;
        REG_PLANE_OFFSET: offset_r    <= $signed(cfg_data[31:0]);
        default: ;
      endcase
    end
  end

  // stage 1: normal products
  logic signed [CB-1:0] in_e [3];
  logic signed [CB-1:0] in_w [3];
  assign in_e[0] = in_origin_x;
  assign in_e[1] = in_origin_y;
  assign in_e[2] = in_origin_z;
  assign in_w[0] = in_dir_x;
  assign in_w[1] = in_dir_y;
  assign in_w[2] = in_dir_z;

  logic                  v1_r;
  side_t                 sd1_r;
  logic signed [PRW-1:0] pe1_r [3];
  logic signed [PRW-1:0] pw1_r [3];
  logic [CB-1:0]         aw1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    sd1_r.cmd    <= in_cmd;
    sd1_r.miss   <= 1'b0;
    sd1_r.maxlen <= in_max_length;
    for (int k = 0; k < 3; k++) begin
      sd1_r.e[k]    <= in_e[k];
      sd1_r.wneg[k] <= in_w[k][CB-1];
      aw1_r[k]      <= in_w[k][CB-1] ? CB'(-in_w[k]) : CB'(in_w[k]);
      pe1_r[k]      <= PRW'($signed(normal_r[16*k +: 16])) * PRW'(in_e[k]);
      pw1_r[k]      <= PRW'($signed(normal_r[16*k +: 16])) * PRW'(in_w[k]);
    end
  end

  // stage 2: numerator and denominator
  logic                   v2_r;
  side_t                  sd2_r;
  logic signed [NUMW-1:0] num2_r;
  logic signed [DENW-1:0] den2_r;
  logic [CB-1:0]          aw2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    sd2_r  <= sd1_r;
    aw2_r  <= aw1_r;
    num2_r <= NUMW'(offset_r) + NUMW'(pe1_r[0]) + NUMW'(pe1_r[1]) + NUMW'(pe1_r[2]);
    den2_r <= DENW'(pw1_r[0]) + DENW'(pw1_r[1]) + DENW'(pw1_r[2]);
  end

  // stage 3: early miss, magnitudes, partial products
  logic              v3_r;
  side_t             sd3_r;
  side_t             sd3_nxt;
  logic [CB+NL-1:0]  pl3_r [3];
  logic [CB+NH-1:0]  ph3_r [3];
  logic [DENW-1:0]   aden3_r;
  logic [NUMW-1:0]   anum;
  logic              miss3;

  always_comb begin
    anum  = num2_r[NUMW-1] ? NUMW'(-num2_r) : NUMW'(num2_r);
    miss3 = (den2_r == '0) ||
            (num2_r > 0 && den2_r > 0) || (num2_r < 0 && den2_r < 0) ||
            (sd2_r.cmd && num2_r == '0);
    sd3_nxt      = sd2_r;
    sd3_nxt.miss = miss3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    sd3_r      <= sd3_nxt;
    aden3_r    <= den2_r[DENW-1] ? DENW'(-den2_r) : DENW'(den2_r);
    for (int k = 0; k < 3; k++) begin
      pl3_r[k] <= (CB+NL)'(aw2_r[k]) * (CB+NL)'(anum[NL-1:0]);
      ph3_r[k] <= (CB+NH)'(aw2_r[k]) * (CB+NH)'(anum[NUMW-1:NL]);
    end
  end

  // stage 4: full product
  logic            v4_r;
  side_t           sd4_r;
  logic [PW-1:0]   p4_r [3];
  logic [DENW-1:0] aden4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    sd4_r   <= sd3_r;
    aden4_r <= aden3_r;
    for (int k = 0; k < 3; k++)
      p4_r[k] <= (PW'(ph3_r[k]) << NL) + PW'(pl3_r[k]);
  end

  // divider: entry 0 loaded here, one quotient bit per stage
  logic            dvv_r  [QB+1];
  side_t           dsd_r  [QB+1];
  logic [RW-1:0]   drem_r [QB+1][3];
  logic [QB-1:0]   dq_r   [QB+1][3];
  logic [QB-1:0]   dlo_r  [QB+1][3];
  logic            dovf_r [QB+1][3];
  logic [DENW-1:0] dden_r [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dvv_r[0] <= 1'b0;
    else        dvv_r[0] <= v4_r;
  end

  always_ff @(posedge clk) begin
    dsd_r[0]  <= sd4_r;
    dden_r[0] <= aden4_r;
    for (int k = 0; k < 3; k++) begin
      dovf_r[0][k] <= CW'(p4_r[k][PW-1:QB]) >= CW'(aden4_r);
      drem_r[0][k] <= RW'(p4_r[k][PW-1:QB]);
      dlo_r[0][k]  <= p4_r[k][QB-1:0];
      dq_r[0][k]   <= '0;
    end
  end

  for (genvar gi = 0; gi < QB; gi++) begin : g_div
    logic [RW-1:0] tr [3];
    logic          ge [3];

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        tr[k] = {drem_r[gi][k][RW-2:0], dlo_r[gi][k][QB-1-gi]};
        ge[k] = tr[k] >= RW'(dden_r[gi]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dvv_r[gi+1] <= 1'b0;
      else        dvv_r[gi+1] <= dvv_r[gi];
    end

    always_ff @(posedge clk) begin
      dsd_r[gi+1]  <= dsd_r[gi];
      dden_r[gi+1] <= dden_r[gi];
      for (int k = 0; k < 3; k++) begin
        drem_r[gi+1][k] <= ge[k] ? tr[k] - RW'(dden_r[gi]) : tr[k];
        dq_r[gi+1][k]   <= {dq_r[gi][k][QB-2:0], ge[k]};
        dlo_r[gi+1][k]  <= dlo_r[gi][k];
        dovf_r[gi+1][k] <= dovf_r[gi][k];
      end
    end
  end

  // round to nearest and clamp
  logic        vr_r;
  side_t       sdr_r;
  logic [QB-1:0] o_r [3];
  logic [QB:0]   qr  [3];

  always_comb begin
    for (int k = 0; k < 3; k++)
      qr[k] = (QB+1)'(dq_r[QB][k]) +
              (QB+1)'({drem_r[QB][k], 1'b0} >= (RW+1)'(dden_r[QB]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vr_r <= 1'b0;
    else        vr_r <= dvv_r[QB];
  end

  always_ff @(posedge clk) begin
    sdr_r <= dsd_r[QB];
    for (int k = 0; k < 3; k++)
      o_r[k] <= (dovf_r[QB][k] || qr[k] > LIM) ? QB'(LIM) : QB'(qr[k]);
  end

  // hit point and distance terms
  logic                vp_r;
  side_t               sdp_r;
  logic [CB-1:0]       pp_r [3];
  logic [DC_BITS-1:0]  dc_r [3];
  logic signed [SW-1:0] psum [3];

  always_comb begin
    logic signed [SW-1:0] os;
    for (int k = 0; k < 3; k++) begin
      os      = $signed(SW'(o_r[k]));
      psum[k] = SW'($signed(sdr_r.e[k])) + (sdr_r.wneg[k] ? -os : os);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= 1'b0;
    else        vp_r <= vr_r;
  end

  always_ff @(posedge clk) begin
    sdp_r <= sdr_r;
    for (int k = 0; k < 3; k++) begin
      if (psum[k] > CMAXV)      pp_r[k] <= CB'(CMAXV);
      else if (psum[k] < CMINV) pp_r[k] <= CB'(CMINV);
      else                      pp_r[k] <= CB'(psum[k]);
      dc_r[k] <= (o_r[k] > QB'(DC_LIM)) ? DC_LIM : DC_BITS'(o_r[k]);
    end
  end

  // squares and edge products
  logic                  vs_r;
  side_t                 sds_r;
  logic [CB-1:0]         ps_r [3];
  logic [SQW-1:0]        sq_r [3];
  logic signed [IPW-1:0] ip_r [4][3];

  always_ff @(posedge clk) begin
    if (!rst_n) vs_r <= 1'b0;
    else        vs_r <= vp_r;
  end

  always_ff @(posedge clk) begin
    logic signed [16:0]    vn;
    logic signed [VPW-1:0] vq;
    sds_r <= sdp_r;
    ps_r  <= pp_r;
    for (int k = 0; k < 3; k++) begin
      sq_r[k] <= SQW'(dc_r[k]) * SQW'(dc_r[k]);
      for (int i = 0; i < 4; i++) begin
        vn = 17'($signed(corner_r[(i+1)%4][16*k +: 16])) -
             17'($signed(corner_r[i][16*k +: 16]));
        vq = VPW'($signed(pp_r[k])) - VPW'($signed(corner_r[i][16*k +: 16]));
        ip_r[i][k] <= IPW'(vn) * IPW'(vq);
      end
    end
  end

  // sums, shadow limit, inside test
  logic                   qvv_r [ST+1];
  fin_t                   qfn_r [ST+1];
  logic [SQW-1:0]         qv_r  [ST+1];
  logic [SQW-1:0]         qr_r  [ST+1];
  logic [SQW-1:0]         ssum;
  logic                   outside;
  logic signed [DOTW-1:0] dot [4];

  always_comb begin
    ssum    = sq_r[0] + sq_r[1] + sq_r[2];
    outside = 1'b0;
    for (int i = 0; i < 4; i++) begin
      dot[i]  = DOTW'(ip_r[i][0]) + DOTW'(ip_r[i][1]) + DOTW'(ip_r[i][2]);
      outside = outside || dot[i][DOTW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) qvv_r[0] <= 1'b0;
    else        qvv_r[0] <= vs_r;
  end

  always_ff @(posedge clk) begin
    qfn_r[0].p    <= {ps_r[2], ps_r[1], ps_r[0]};
    qfn_r[0].miss <= sds_r.miss || outside ||
                     (sds_r.cmd &&
                      ssum >= SQW'(32'(sds_r.maxlen) * 32'(sds_r.maxlen)));
    qv_r[0]       <= ssum;
    qr_r[0]       <= '0;
  end

  // square root, one result bit per stage
  for (genvar gj = 0; gj < ST; gj++) begin : g_sqrt
    localparam logic [SQW-1:0] SBIT = SQW'(1) << (2 * (ST - 1 - gj));
    logic take;
    assign take = qv_r[gj] >= qr_r[gj] + SBIT;

    always_ff @(posedge clk) begin
      if (!rst_n) qvv_r[gj+1] <= 1'b0;
      else        qvv_r[gj+1] <= qvv_r[gj];
    end

    always_ff @(posedge clk) begin
      qfn_r[gj+1] <= qfn_r[gj];
      if (take) begin
        qv_r[gj+1] <= qv_r[gj] - (qr_r[gj] + SBIT);
        qr_r[gj+1] <= (qr_r[gj] >> 1) + SBIT;
      end else begin
        qv_r[gj+1] <= qv_r[gj];
        qr_r[gj+1] <= qr_r[gj] >> 1;
      end
    end
  end

  // output register
  logic          out_valid_r;
  logic          out_hit_r;
  logic [15:0]   out_dist_r;
  logic [CB-1:0] out_p_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= qvv_r[ST];
  end

  always_ff @(posedge clk) begin
    out_hit_r  <= !qfn_r[ST].miss;
    if (qfn_r[ST].miss)                out_dist_r <= '0;
    else if (qr_r[ST] > SQW'(16'hFFFF)) out_dist_r <= 16'hFFFF;
    else                               out_dist_r <= qr_r[ST][15:0];
    for (int k = 0; k < 3; k++)
      out_p_r[k] <= qfn_r[ST].miss ? '0 : qfn_r[ST].p[k];
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = out_dist_r;
  assign out_point_x  = $signed(out_p_r[0]);
  assign out_point_y  = $signed(out_p_r[1]);
  assign out_point_z  = $signed(out_p_r[2]);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("beat did not leave at fixed latency");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |->
      (out_distance == '0 && out_point_x == '0 && out_point_y == '0 &&
       out_point_z == '0))
    else $error("miss carries nonzero payload");

  a_offset_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    vr_r |-> ((QB+1)'(o_r[0]) <= LIM && (QB+1)'(o_r[1]) <= LIM &&
              (QB+1)'(o_r[2]) <= LIM))
    else $error("offset beyond clamp");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("strobe right after reset");

endmodule
`default_nettype wire

### test/rri_checker.sv
`timescale 1ns / 100ps
module rri_checker #(
  parameter int CB = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 in_cmd,
  input  logic signed [CB-1:0] in_origin_x,
  input  logic signed [CB-1:0] in_origin_y,
  input  logic signed [CB-1:0] in_origin_z,
  input  logic signed [CB-1:0] in_dir_x,
  input  logic signed [CB-1:0] in_dir_y,
  input  logic signed [CB-1:0] in_dir_z,
  input  logic [15:0]          in_max_length,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [47:0]          cfg_data,
  input  logic                 out_valid,
  input  logic                 out_hit,
  input  logic [15:0]          out_distance,
  input  logic signed [CB-1:0] out_point_x,
  input  logic signed [CB-1:0] out_point_y,
  input  logic signed [CB-1:0] out_point_z,
  output int                   fail_count,
  output int                   pending
);
  import rri_pkg::*;

  typedef struct {
    logic                 hit;
    logic [15:0]          range_q8;
    logic signed [CB-1:0] px;
    logic signed [CB-1:0] py;
    logic signed [CB-1:0] pz;
  } hit_t;

  localparam longint CMAX = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam longint unsigned OFF_LIM = 64'd1 << 33;
  localparam longint DC_LIM = 64'sd1 <<< 17;

  logic [47:0] corner_r [4];
  logic [47:0] normal_r;
  logic [31:0] offset_r;
  hit_t hits_q [$];

  assign pending = hits_q.size();

  function automatic longint corner_lane(logic [47:0] r, int k);
    logic signed [15:0] v;
    v = r[16*k +: 16];
    return longint'(v);
  endfunction

  function automatic longint unsigned scaled_quot(longint unsigned a, longint unsigned b,
                                                  longint unsigned c, longint unsigned lim);
    logic [127:0] p, q, r;
    p = {64'd0, a} * {64'd0, b};
    q = p / {64'd0, c};
    r = p % {64'd0, c};
    if (q > {64'd0, lim}) return lim;
    if (r >= {64'd0, c} - r) q = q + 1;
    if (q > {64'd0, lim}) return lim;
    return q[63:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic hit_t trace_ray(logic cmd, logic signed [CB-1:0] ex, ey, ez,
                                     logic signed [CB-1:0] wx, wy, wz, logic [15:0] ml);
    hit_t res;
    longint e [3];
    longint w [3];
    longint p [3];
    longint num, den, o, dc, ci, dot;
    longint unsigned sumsq, m, root, mlsq;
    logic in_rect;
    res = '{hit: 1'b0, range_q8: '0, px: '0, py: '0, pz: '0};
    e[0] = longint'(ex); e[1] = longint'(ey); e[2] = longint'(ez);
    w[0] = longint'(wx); w[1] = longint'(wy); w[2] = longint'(wz);
    num = longint'($signed(offset_r));
    den = 0;
    for (int k = 0; k < 3; k++) begin
      num += corner_lane(normal_r, k) * e[k];
      den += corner_lane(normal_r, k) * w[k];
    end
    if (den == 0) return res;
    if ((num > 0 && den > 0) || (num < 0 && den < 0)) return res;
    if (cmd && num == 0) return res;
    sumsq = 0;
    for (int k = 0; k < 3; k++) begin
      m = scaled_quot(w[k] < 0 ? -w[k] : w[k], num < 0 ? -num : num,
                      den < 0 ? -den : den, OFF_LIM);
      o = longint'(m);
      p[k] = e[k] + (w[k] < 0 ? -o : o);
      if (p[k] > CMAX) p[k] = CMAX;
      if (p[k] < CMIN) p[k] = CMIN;
      dc = o > DC_LIM ? DC_LIM : o;
      sumsq += longint'(dc * dc);
    end
    mlsq = longint'(ml) * longint'(ml);
    if (cmd && sumsq >= mlsq) return res;
    in_rect = 1'b1;
    for (int i = 0; i < 4; i++) begin
      dot = 0;
      for (int k = 0; k < 3; k++) begin
        ci = corner_lane(corner_r[i], k);
        dot += (corner_lane(corner_r[(i + 1) % 4], k) - ci) * (p[k] - ci);
      end
      if (dot < 0) in_rect = 1'b0;
    end
    if (!in_rect) return res;
    root = int_sqrt(sumsq);
    if (root > 64'hFFFF) root = 64'hFFFF;
    res.hit = 1'b1;
    res.range_q8 = root[15:0];
    res.px = p[0][CB-1:0];
    res.py = p[1][CB-1:0];
    res.pz = p[2][CB-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    hit_t exp_h;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) corner_r[i] <= '0;
      normal_r <= '0;
      offset_r <= '0;
      hits_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CORNER_A: corner_r[0] <= cfg_data;
          REG_CORNER_B: corner_r[1] <= cfg_data;
          REG_CORNER_C: corner_r[2] <= cfg_data;
          REG_CORNER_D: corner_r[3] <= cfg_data;
          REG_PLANE_NORMAL: normal_r <= cfg_data;
          REG_PLANE_OFFSET: offset_r <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (hits_q.size() == 0) begin
          $display("%0t: unexpected result beat hit %b dist %h", $time, out_hit, out_distance);
          fail_count <= fail_count + 1;
        end else begin
          exp_h = hits_q.pop_front();
          if (out_hit !== exp_h.hit || out_distance !== exp_h.range_q8 ||
              out_point_x !== exp_h.px || out_point_y !== exp_h.py ||
              out_point_z !== exp_h.pz) begin
            $display("%0t: mismatch exp hit %b dist %h pt %h %h %h act hit %b dist %h pt %h %h %h",
                     $time, exp_h.hit, exp_h.range_q8, exp_h.px, exp_h.py, exp_h.pz,
                     out_hit, out_distance, out_point_x, out_point_y, out_point_z);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        hits_q.insert(hits_q.size(),
                      trace_ray(in_cmd, in_origin_x, in_origin_y, in_origin_z,
                                in_dir_x, in_dir_y, in_dir_z, in_max_length));
    end
  end
endmodule

### test/tb_ray_rectangle_intersect.sv
`timescale 1ns / 100ps
module tb_ray_rectangle_intersect;
  import rri_pkg::*;

  localparam int CB = 16;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = 1'b0;
  logic signed [CB-1:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [CB-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic [15:0] in_max_length = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic out_valid, out_hit;
  logic [15:0] out_distance;
  logic signed [CB-1:0] out_point_x, out_point_y, out_point_z;
  int fail_count, pending;
  int idle_cycles = 0;

  int plane_ax, plane_z0, plane_half;
  bit no_idle;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ray_rectangle_intersect #(.COORD_BITS(CB)) dut (.*);

  rri_checker #(.CB(CB)) chk (.*);

  always @(posedge clk) begin
    if ((start && !busy) || (cfg_valid && cfg_ready) || out_valid || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int rnd_s(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  function automatic logic [47:0] pack3(int ax, int n, int u, int v);
    logic [15:0] l [3];
    l[ax] = n[15:0];
    l[(ax + 1) % 3] = u[15:0];
    l[(ax + 2) % 3] = v[15:0];
    return {l[2], l[1], l[0]};
  endfunction

  task automatic gap();
    int g;
    if (no_idle || $urandom_range(99) < 65) return;
    g = ($urandom_range(99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 80);
    start <= 1'b0;
    repeat (g) @(posedge clk);
  endtask

  task automatic send_ray(logic cmd, int ox, int oy, int oz, int wx, int wy, int wz, int ml);
    start <= 1'b1;
    in_cmd <= cmd;
    in_origin_x <= ox[CB-1:0];
    in_origin_y <= oy[CB-1:0];
    in_origin_z <= oz[CB-1:0];
    in_dir_x <= wx[CB-1:0];
    in_dir_y <= wy[CB-1:0];
    in_dir_z <= wz[CB-1:0];
    in_max_length <= ml[15:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    gap();
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [47:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_rect(int ax, int z0, int half, bit flip);
    int nz;
    plane_ax = ax;
    plane_z0 = z0;
    plane_half = half;
    nz = flip ? -16384 : 16384;
    cfg_write(REG_CORNER_A, pack3(ax, z0, -half, -half));
    cfg_write(REG_CORNER_B, pack3(ax, z0, half, -half));
    cfg_write(REG_CORNER_C, pack3(ax, z0, half, half));
    cfg_write(REG_CORNER_D, pack3(ax, z0, -half, half));
    cfg_write(REG_PLANE_NORMAL, pack3(ax, nz, 0, 0));
    cfg_write(REG_PLANE_OFFSET, {16'h0, 32'(-(nz * z0))});
  endtask

  task automatic aimed_ray();
    int o [3];
    int w [3];
    int side, ml;
    logic cmd;
    side = $urandom_range(1) ? 1 : -1;
    o[plane_ax] = plane_z0 + side * int'($urandom_range(4000));
    o[(plane_ax + 1) % 3] = rnd_s(plane_half * 2);
    o[(plane_ax + 2) % 3] = rnd_s(plane_half * 2);
    w[plane_ax] = ($urandom_range(9) < 8 ? -side : side) * int'($urandom_range(1, 600));
    w[(plane_ax + 1) % 3] = rnd_s(500);
    w[(plane_ax + 2) % 3] = rnd_s(500);
    if ($urandom_range(19) == 0) w[plane_ax] = 0;
    cmd = 1'($urandom_range(1));
    ml = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(12000);
    send_ray(cmd, o[0], o[1], o[2], w[0], w[1], w[2], ml);
  endtask

  task automatic noise_ray();
    send_ray(1'($urandom_range(1)), $urandom_range(65535), $urandom_range(65535),
             $urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
             $urandom_range(65535), $urandom_range(65535));
  endtask

  task automatic run_phase(int count, int aimed_pct);
    for (int i = 0; i < count; i++) begin
      if (int'($urandom_range(99)) < aimed_pct) aimed_ray();
      else noise_ray();
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: normal of zero, every ray misses
    no_idle = 1'b1;
    send_ray(1'b0, 256, 256, 256, 256, 0, 0, 100);
    send_ray(1'b1, 32767, -32768, 0, -32768, 32767, 1, 65535);
    drain();
    cfg_write(reg_idx_t'(3'd6), 48'hFFFF_FFFF_FFFF);
    cfg_write(reg_idx_t'(3'd7), 48'h1234_5678_9ABC);
    set_rect(2, 0, 2560, 1'b0);
    send_ray(1'b0, 0, 0, 2560, 0, 0, -256, 0);
    send_ray(1'b0, 0, 0, 2560, 0, 0, 256, 0);
    send_ray(1'b0, 0, 0, 2560, 256, 0, 0, 0);
    send_ray(1'b1, 0, 0, 0, 0, 0, -256, 1000);
    send_ray(1'b0, 0, 0, 0, 0, 0, -256, 0);
    send_ray(1'b0, 2560, 2560, 256, 0, 0, -256, 0);
    send_ray(1'b0, 2561, 0, 256, 0, 0, -256, 0);
    send_ray(1'b1, 0, 0, 2560, 0, 0, -256, 2560);
    send_ray(1'b1, 0, 0, 2560, 0, 0, -256, 2561);
    send_ray(1'b1, 0, 0, 2560, 0, 0, -256, 65535);
    send_ray(1'b0, 0, 0, 32767, 32767, 32767, -1, 0);
    send_ray(1'b0, -32768, -32768, -32768, 32767, 32767, 32767, 0);
    send_ray(1'b1, 0, 0, 1, -32768, 32767, -1, 65535);
    send_ray(1'b0, 100, -100, -1, 7, -9, 1, 0);
    drain();
    cfg_write(REG_PLANE_OFFSET, 48'hFFFF_8000_0000);
    send_ray(1'b0, 0, 0, 0, 0, 0, 256, 0);
    drain();

    no_idle = 1'b0;
    set_rect(2, 1000, 3000, 1'b0);
    run_phase(250, 85);
    no_idle = 1'b1;
    set_rect(0, -5000, 800, 1'b1);
    run_phase(200, 85);
    no_idle = 1'b0;
    set_rect(1, 20000, 32767, 1'b0);
    run_phase(200, 85);
    set_rect(2, -32768, 16000, 1'b1);
    run_phase(200, 85);

    cfg_write(REG_CORNER_A, 48'h8000_8000_8000);
    cfg_write(REG_CORNER_B, 48'h7FFF_7FFF_7FFF);
    cfg_write(REG_CORNER_C, 48'hFFFF_FFFF_FFFF);
    cfg_write(REG_CORNER_D, 48'h0000_0000_0000);
    cfg_write(REG_PLANE_NORMAL, 48'h7FFF_8000_7FFF);
    cfg_write(REG_PLANE_OFFSET, 48'h0000_7FFF_FFFF);
    run_phase(150, 0);

    for (int ph = 0; ph < 2; ph++) begin
      cfg_write(REG_CORNER_A, 48'({$urandom, $urandom}));
      cfg_write(REG_CORNER_B, 48'({$urandom, $urandom}));
      cfg_write(REG_CORNER_C, 48'({$urandom, $urandom}));
      cfg_write(REG_CORNER_D, 48'({$urandom, $urandom}));
      cfg_write(REG_PLANE_NORMAL, 48'({$urandom, $urandom}));
      cfg_write(REG_PLANE_OFFSET, 48'({$urandom, $urandom}));
      run_phase(100, 0);
    end

    set_rect(2, 0, 6000, 1'b0);
    run_phase(200, 90);

    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
